@@ rtl/core/aac_pkg.sv @@
// Shared widths, constants and the arctangent table for the aspect angle core.
// No dependencies; every other file in rtl/core imports this package.
package aac_pkg;

  // Input field widths
  localparam int POS_W = 24;
  localparam int VEC_W = 16;

  // Line of sight, projected vector and normalized operand widths
  localparam int D_W    = POS_W + 1;
  localparam int DU_W   = D_W + VEC_W + 2;
  localparam int DUP_W  = DU_W + VEC_W;
  localparam int PROJ_SHIFT = 28;
  localparam int A_W    = 62;
  localparam int B_W    = VEC_W + 1;
  localparam int NORM_BITS = 24;
  localparam int N_W    = NORM_BITS + 1;
  localparam int SH_W   = 6;
  localparam int PRD_W  = N_W + B_W;
  localparam int CRS_W  = PRD_W + 1;
  localparam int DOT_W  = PRD_W + 2;

  // CORDIC datapath widths
  localparam int CW     = 48;
  localparam int ZW     = 26;
  localparam int AT_W   = 22;
  localparam int ATAN_LEN = 24;
  localparam int Z_90   = 90 * 65536;
  localparam int RND_HALF = 256;
  localparam int RND_SHIFT = 9;

  // Result angle
  localparam int ANG_W     = 15;
  localparam int ANGLE_MAX = 23040;

  // Zero-vector flags of one angle operand pair
  typedef struct packed {
    logic a_zero;
    logic b_zero;
  } vec_flags_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic [AT_W-1:0] atan_entry(input int idx);
    logic [AT_W-1:0] v;
    v = '0;
    case (idx)
      0:  v = AT_W'(2949120);
      1:  v = AT_W'(1740967);
      2:  v = AT_W'(919879);
      3:  v = AT_W'(466945);
      4:  v = AT_W'(234379);
      5:  v = AT_W'(117304);
      6:  v = AT_W'(58666);
      7:  v = AT_W'(29335);
      8:  v = AT_W'(14668);
      9:  v = AT_W'(7334);
      10: v = AT_W'(3667);
      11: v = AT_W'(1833);
      12: v = AT_W'(917);
      13: v = AT_W'(458);
      14: v = AT_W'(229);
      15: v = AT_W'(115);
      16: v = AT_W'(57);
      17: v = AT_W'(29);
      18: v = AT_W'(14);
      19: v = AT_W'(7);
      20: v = AT_W'(4);
      21: v = AT_W'(2);
      22: v = AT_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/aac_vec.sv @@
// Operand unit: normalizes the first vector and forms cross and dot products.
// Five register stages, all advanced by en_i. Depends on aac_pkg.
module aac_vec (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [aac_pkg::A_W-1:0]      a_i [3],
  input  logic signed [aac_pkg::B_W-1:0]      b_i [3],
  output logic signed [aac_pkg::CRS_W-1:0]    c_o [3],
  output logic signed [aac_pkg::DOT_W-1:0]    dot_o,
  output aac_pkg::vec_flags_t                 flags_o
);
  import aac_pkg::*;

  logic signed [A_W-1:0]   a1_q [3];
  logic signed [B_W-1:0]   b1_q [3];
  logic [A_W-1:0]          or1_d, or1_q;
  vec_flags_t              f1_d, f1_q;

  logic signed [A_W-1:0]   a2_q [3];
  logic signed [B_W-1:0]   b2_q [3];
  logic [SH_W-1:0]         s2_d, s2_q;
  vec_flags_t              f2_q;

  logic signed [N_W-1:0]   a3_d [3];
  logic signed [N_W-1:0]   a3_q [3];
  logic signed [B_W-1:0]   b3_q [3];
  vec_flags_t              f3_q;

  logic signed [PRD_W-1:0] pr4_q [9];
  vec_flags_t              f4_q;

  logic signed [CRS_W-1:0] c5_q [3];
  logic signed [DOT_W-1:0] dot5_q;
  vec_flags_t              f5_q;

  // Gather magnitude bits of all components and zero tests
  always_comb begin
    logic [A_W-1:0] m;
    or1_d = '0;
    for (int k = 0; k < 3; k++) begin
      m = a_i[k][A_W-1] ? A_W'(-a_i[k]) : A_W'(a_i[k]);
      or1_d = or1_d | m;
    end
    f1_d.a_zero = (or1_d == '0);
    f1_d.b_zero = (b_i[0] == '0) && (b_i[1] == '0) && (b_i[2] == '0);
  end

  // Find the right shift that brings the largest magnitude below 2^24
  always_comb begin
    logic [SH_W-1:0] bl;
    bl = '0;
    for (int k = 0; k < A_W; k++) begin
      if (or1_q[k]) bl = SH_W'(k + 1);
    end
    s2_d = (bl > SH_W'(NORM_BITS)) ? SH_W'(bl - SH_W'(NORM_BITS)) : '0;
  end

  // Apply the floor shift
  always_comb begin
    logic signed [A_W-1:0] sh;
    for (int k = 0; k < 3; k++) begin
      sh = a2_q[k] >>> s2_q;
      a3_d[k] = sh[N_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= a_i;
      b1_q  <= b_i;
      or1_q <= or1_d;
      f1_q  <= f1_d;

      a2_q  <= a1_q;
      b2_q  <= b1_q;
      s2_q  <= s2_d;
      f2_q  <= f1_q;

      a3_q  <= a3_d;
      b3_q  <= b2_q;
      f3_q  <= f2_q;

      // Cross and dot partial products
      pr4_q[0] <= a3_q[1] * b3_q[2];
      pr4_q[1] <= a3_q[2] * b3_q[1];
      pr4_q[2] <= a3_q[2] * b3_q[0];
      pr4_q[3] <= a3_q[0] * b3_q[2];
      pr4_q[4] <= a3_q[0] * b3_q[1];
      pr4_q[5] <= a3_q[1] * b3_q[0];
      pr4_q[6] <= a3_q[0] * b3_q[0];
      pr4_q[7] <= a3_q[1] * b3_q[1];
      pr4_q[8] <= a3_q[2] * b3_q[2];
      f4_q     <= f3_q;

      // Combine partial products
      c5_q[0] <= CRS_W'(pr4_q[0]) - CRS_W'(pr4_q[1]);
      c5_q[1] <= CRS_W'(pr4_q[2]) - CRS_W'(pr4_q[3]);
      c5_q[2] <= CRS_W'(pr4_q[4]) - CRS_W'(pr4_q[5]);
      dot5_q  <= DOT_W'(pr4_q[6]) + DOT_W'(pr4_q[7]) + DOT_W'(pr4_q[8]);
      f5_q    <= f4_q;
    end
  end

  assign c_o     = c5_q;
  assign dot_o   = dot5_q;
  assign flags_o = f5_q;

endmodule

@@ rtl/core/aac_mag_cell.sv @@
// One CORDIC vectoring stage of a magnitude pass; stage zero folds x to |x|.
// Depends on aac_pkg.
module aac_mag_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [aac_pkg::CW-1:0] x_i,
  input  logic signed [aac_pkg::CW-1:0] y_i,
  output logic signed [aac_pkg::CW-1:0] x_o,
  output logic signed [aac_pkg::CW-1:0] y_o
);
  import aac_pkg::*;

  logic signed [CW-1:0] xs, tx, ty, x_d, y_d, x_q, y_q;

  // Rotate toward the x axis
  always_comb begin
    xs = (IDX == 0 && x_i[CW-1]) ? -x_i : x_i;
    tx = xs >>> IDX;
    ty = y_i >>> IDX;
    if (!y_i[CW-1]) begin
      x_d = xs + ty;
      y_d = y_i - tx;
    end else begin
      x_d = xs - ty;
      y_d = y_i + tx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

@@ rtl/core/aac_gain_cell.sv @@
// One stage of the dot product path: applies the CORDIC gain step or delays.
// Depends on aac_pkg.
module aac_gain_cell #(
  parameter int IDX  = 0,
  parameter bit GAIN = 1'b1
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [aac_pkg::CW-1:0] g_i,
  output logic signed [aac_pkg::CW-1:0] g_o
);
  import aac_pkg::*;

  logic signed [CW-1:0] g_d, g_q;

  // Scale by (1 + 4^-IDX) with a floor shift
  always_comb begin
    g_d = GAIN ? (g_i + (g_i >>> (2 * IDX))) : g_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) g_q <= g_d;
  end

  assign g_o = g_q;

endmodule

@@ rtl/core/aac_ang_cell.sv @@
// One CORDIC angle stage; stage zero first turns a left half-plane vector by 90 degrees.
// Depends on aac_pkg (arctangent table).
module aac_ang_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [aac_pkg::CW-1:0] x_i,
  input  logic signed [aac_pkg::CW-1:0] y_i,
  input  logic signed [aac_pkg::ZW-1:0] z_i,
  output logic signed [aac_pkg::CW-1:0] x_o,
  output logic signed [aac_pkg::CW-1:0] y_o,
  output logic signed [aac_pkg::ZW-1:0] z_o
);
  import aac_pkg::*;

  localparam logic [AT_W-1:0] AtanStep = atan_entry(IDX);

  logic signed [CW-1:0] xs, ys, tx, ty, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] zs, at, z_d, z_q;

  always_comb begin
    // Bring the vector into the right half plane
    if (IDX == 0 && x_i[CW-1]) begin
      xs = y_i;
      ys = -x_i;
      zs = ZW'(Z_90);
    end else begin
      xs = x_i;
      ys = y_i;
      zs = z_i;
    end
    at = $signed({{(ZW-AT_W){1'b0}}, AtanStep});
    tx = xs >>> IDX;
    ty = ys >>> IDX;
    if (!ys[CW-1]) begin
      x_d = xs + ty;
      y_d = ys - tx;
      z_d = zs + at;
    end else begin
      x_d = xs - ty;
      y_d = ys + tx;
      z_d = zs - at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

@@ rtl/core/aspect_angle_compute_core.sv @@
// Aspect angle core: nose (projected) and tail (3D) angles of a line of sight.
// Five projection stages, five operand stages, two magnitude passes in series
// and one angle pass. Throughput one request per cycle; the whole pipeline
// stalls only while a result waits at the output. Reset clears the valid
// bits only.
// Depends on aac_pkg, aac_vec, aac_mag_cell, aac_gain_cell, aac_ang_cell.
module aspect_angle_compute_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // own_x, own_y, own_z, tgt_x, tgt_y, tgt_z, fwd_x, fwd_y, fwd_z, up_x, up_y, up_z
  input  logic [239:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // aspect_nose_deg, aspect_tail_deg, zero padding
  output logic [31:0]  m_axis_tdata_o,
  // degenerate
  output logic         m_axis_tuser_o
);
  import aac_pkg::*;

  localparam int NS   = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int FD   = 3 * NS;
  localparam int VL   = 10 + FD;
  localparam int TGT_OFS = 3 * POS_W;
  localparam int FWD_OFS = 6 * POS_W;
  localparam int UP_OFS  = 6 * POS_W + 3 * VEC_W;

  typedef struct packed {
    logic nose_ok;
    logic tail_ok;
    logic degen;
  } res_flags_t;

  logic adv;
  logic [VL-1:0] vld_q;
  logic out_vld_q;

  logic signed [POS_W-1:0] own [3];
  logic signed [POS_W-1:0] tgt [3];
  logic signed [VEC_W-1:0] fwd [3];
  logic signed [VEC_W-1:0] up  [3];

  logic signed [D_W-1:0]   d1_q [3], d2_q [3], d3_q [3], d4_q [3], d5_q [3];
  logic signed [VEC_W-1:0] u1_q [3], u2_q [3], u3_q [3];
  logic signed [VEC_W-1:0] f1_q [3], f2_q [3], f3_q [3], f4_q [3], f5_q [3];
  logic signed [DU_W-3:0]  pu2_q [3];
  logic signed [DU_W-1:0]  du3_q;
  logic signed [DUP_W-1:0] dup4_q [3];
  logic signed [A_W-1:0]   p5_q [3];

  logic signed [A_W-1:0]   na [3], ta [3];
  logic signed [B_W-1:0]   nb [3], tb [3];
  logic signed [CRS_W-1:0] nc [3], tc [3];
  logic signed [DOT_W-1:0] ndot, tdot;
  vec_flags_t              nflg, tflg;
  res_flags_t              flg_q [FD];

  logic signed [ZW-1:0]    nz_end, tz_end;
  logic [ANG_W-1:0]        nose_ang, tail_ang;
  logic [ANG_W-1:0]        nose_q, tail_q;
  logic                    degen_q;

  // Whole pipeline advances unless a result is held at the output
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Unpack the request
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      own[k] = s_axis_tdata_i[k*POS_W +: POS_W];
      tgt[k] = s_axis_tdata_i[TGT_OFS + k*POS_W +: POS_W];
      fwd[k] = s_axis_tdata_i[FWD_OFS + k*VEC_W +: VEC_W];
      up[k]  = s_axis_tdata_i[UP_OFS + k*VEC_W +: VEC_W];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[VL-2:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[VL-1];
    end
  end

  // Projection of the line of sight onto the plane normal to up
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d1_q[k] <= D_W'(own[k]) - D_W'(tgt[k]);
        u1_q[k] <= up[k];
        f1_q[k] <= fwd[k];

        pu2_q[k] <= d1_q[k] * u1_q[k];
        d2_q[k]  <= d1_q[k];
        u2_q[k]  <= u1_q[k];
        f2_q[k]  <= f1_q[k];

        d3_q[k] <= d2_q[k];
        u3_q[k] <= u2_q[k];
        f3_q[k] <= f2_q[k];

        dup4_q[k] <= du3_q * u3_q[k];
        d4_q[k]   <= d3_q[k];
        f4_q[k]   <= f3_q[k];

        p5_q[k] <= A_W'($signed({d4_q[k], {PROJ_SHIFT{1'b0}}})) - A_W'(dup4_q[k]);
        d5_q[k] <= d4_q[k];
        f5_q[k] <= f4_q[k];
      end
      du3_q <= DU_W'(pu2_q[0]) + DU_W'(pu2_q[1]) + DU_W'(pu2_q[2]);
    end
  end

  // Operands: projection against fwd, line of sight against -fwd
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      na[k] = p5_q[k];
      nb[k] = B_W'(f5_q[k]);
      ta[k] = A_W'(d5_q[k]);
      tb[k] = -(B_W'(f5_q[k]));
    end
  end

  aac_vec u_vec_nose (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (na),
    .b_i    (nb),
    .c_o    (nc),
    .dot_o  (ndot),
    .flags_o(nflg)
  );

  aac_vec u_vec_tail (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (ta),
    .b_i    (tb),
    .c_o    (tc),
    .dot_o  (tdot),
    .flags_o(tflg)
  );

  // Carry result flags alongside the CORDIC cells
  always_ff @(posedge clk_i) begin
    if (adv) begin
      flg_q[0].nose_ok <= !nflg.a_zero && !nflg.b_zero;
      flg_q[0].tail_ok <= !tflg.a_zero && !tflg.b_zero;
      flg_q[0].degen   <= nflg.a_zero || nflg.b_zero || tflg.a_zero;
      for (int k = 1; k < FD; k++) flg_q[k] <= flg_q[k-1];
    end
  end

  // Two identical CORDIC rows, one per angle
  for (genvar v = 0; v < 2; v++) begin : g_row
    logic signed [CW-1:0] xa [NS+1];
    logic signed [CW-1:0] ya [NS+1];
    logic signed [CW-1:0] xb [NS+1];
    logic signed [CW-1:0] yb [NS+1];
    logic signed [CW-1:0] xc [NS+1];
    logic signed [CW-1:0] yc [NS+1];
    logic signed [CW-1:0] g  [2*NS+1];
    logic signed [CW-1:0] xz [NS+1];
    logic signed [CW-1:0] yz [NS+1];
    logic signed [ZW-1:0] zz [NS+1];

    if (v == 0) begin : g_nose
      assign xa[0] = CW'(nc[0]);
      assign ya[0] = CW'(nc[1]);
      assign xb[0] = CW'(nc[2]);
      assign g[0]  = CW'(ndot);
      assign nz_end = zz[NS];
    end else begin : g_tail
      assign xa[0] = CW'(tc[0]);
      assign ya[0] = CW'(tc[1]);
      assign xb[0] = CW'(tc[2]);
      assign g[0]  = CW'(tdot);
      assign tz_end = zz[NS];
    end
    assign yb[0] = '0;
    assign xc[0] = xa[NS];
    assign yc[0] = xb[NS];
    assign xz[0] = g[2*NS];
    assign yz[0] = xc[NS];
    assign zz[0] = '0;

    for (genvar i = 0; i < NS; i++) begin : g_cell
      aac_mag_cell #(.IDX(i)) u_mag_a (
        .clk_i(clk_i), .en_i(adv),
        .x_i(xa[i]), .y_i(ya[i]), .x_o(xa[i+1]), .y_o(ya[i+1])
      );
      aac_mag_cell #(.IDX(i)) u_mag_b (
        .clk_i(clk_i), .en_i(adv),
        .x_i(xb[i]), .y_i(yb[i]), .x_o(xb[i+1]), .y_o(yb[i+1])
      );
      aac_mag_cell #(.IDX(i)) u_mag_c (
        .clk_i(clk_i), .en_i(adv),
        .x_i(xc[i]), .y_i(yc[i]), .x_o(xc[i+1]), .y_o(yc[i+1])
      );
      aac_gain_cell #(.IDX(i), .GAIN(1'b1)) u_gain (
        .clk_i(clk_i), .en_i(adv), .g_i(g[i]), .g_o(g[i+1])
      );
      aac_gain_cell #(.IDX(i), .GAIN(1'b0)) u_dly (
        .clk_i(clk_i), .en_i(adv), .g_i(g[NS+i]), .g_o(g[NS+i+1])
      );
      aac_ang_cell #(.IDX(i)) u_ang (
        .clk_i(clk_i), .en_i(adv),
        .x_i(xz[i]), .y_i(yz[i]), .z_i(zz[i]),
        .x_o(xz[i+1]), .y_o(yz[i+1]), .z_o(zz[i+1])
      );
    end
  end

  // Round to 1/128 degree and clamp
  function automatic logic [ANG_W-1:0] to_deg(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] zr;
    logic signed [ZW:0] rs;
    zr = (ZW+1)'(z) + (ZW+1)'(RND_HALF);
    rs = zr >>> RND_SHIFT;
    if (rs[ZW]) return '0;
    if (rs > (ZW+1)'(ANGLE_MAX)) return ANG_W'(ANGLE_MAX);
    return rs[ANG_W-1:0];
  endfunction

  assign nose_ang = to_deg(nz_end);
  assign tail_ang = to_deg(tz_end);

  // Output register; zero angles of degenerate operands
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nose_q  <= flg_q[FD-1].nose_ok ? nose_ang : '0;
      tail_q  <= flg_q[FD-1].tail_ok ? tail_ang : '0;
      degen_q <= flg_q[FD-1].degen;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, tail_q, nose_q};
  assign m_axis_tuser_o  = degen_q;

endmodule

@@ rtl/core/aac_port_checker.sv @@
// Port-level checks for the aspect angle core, attached by bind.
// Depends on aac_pkg and aspect_angle_compute_core.
module aac_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);
  import aac_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Requests flow whenever no result waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("request refused with empty output");

  // Angles stay within 0..180 degrees
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[14:0] <= 15'(ANGLE_MAX))
                     && (m_axis_tdata_o[29:15] <= 15'(ANGLE_MAX)))
    else $error("angle out of range");

  // Degenerate results carry no nose angle
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[14:0] == '0)
    else $error("nose angle on degenerate result");

endmodule

bind aspect_angle_compute_core aac_port_checker u_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
